// File: design/rrts_pkg.sv
package rrts_pkg;

  localparam int DEF_THREAD_SLOTS = 32;
  localparam int DEF_TASK_SLOTS   = 16;

  localparam int REQ_W    = 3;
  localparam int SLOT_FW  = 5;
  localparam int OWNER_FW = 4;
  localparam int TID_W    = 32;
  localparam int STATE_W  = 3;
  localparam int STAT_W   = 3;
  localparam int COUNT_FW = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE   = 3'd0,
    REQ_DISPATCH = 3'd1,
    REQ_YIELD    = 3'd2,
    REQ_BLOCK    = 3'd3,
    REQ_UNBLOCK  = 3'd4,
    REQ_EXIT     = 3'd5,
    REQ_QUERY    = 3'd6
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_BADARG  = 3'd2,
    STAT_EMPTYQ  = 3'd3,
    STAT_IGNORED = 3'd4
  } stat_e;

  typedef enum logic [STATE_W-1:0] {
    ST_EMPTY   = 3'd0,
    ST_READY   = 3'd1,
    ST_RUNNING = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_DEAD    = 3'd4
  } thr_state_e;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [SLOT_FW-1:0]  target_slot;
    logic [OWNER_FW-1:0] owner_task;
    logic                args_valid;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [SLOT_FW-1:0]  result_slot;
    logic [TID_W-1:0]    result_tid;
    logic [STATE_W-1:0]  result_state;
    logic [SLOT_FW-1:0]  running_slot;
    logic                running_idle;
    logic [COUNT_FW-1:0] ready_count;
  } rsp_t;

endpackage

// File: design/round_robin_thread_scheduler.sv
// round-robin thread scheduler for one cpu with a linked fifo run queue
//
// input channel: in_valid_i / in_stall_o carry one request (req_t) per
// transaction: create, dispatch, yield, block, unblock, exit or query.
// output channel: out_valid_o / out_stall_i carry exactly one response
// (rsp_t) per request, in request order.
//
// a request is accepted in s_idle, which issues the slot-table and link-table
// reads; s_exec then does the read-modify-write and loads the output
// register, waiting there while a held response stalls the output. a new
// request is accepted only in s_idle, so no request is taken before the last
// one has left s_exec. out_valid_o rises at the clock edge that ends s_exec.
//
// if the receiver stalls, the response holds in the output register; one more
// request is still accepted and waits in s_exec until the output
// register frees up, then in_stall_o drops again.
//
// reset (rst_ni low, asynchronous) empties every slot, clears the run queue,
// makes the scheduler context current and sets the next thread id to one.
// slots are handed out lowest first and never reused, so a fill count marks
// which table entries are valid; no clearing pass is needed.
module round_robin_thread_scheduler
  import rrts_pkg::*;
#(
  parameter int THREAD_SLOTS = DEF_THREAD_SLOTS,
  parameter int TASK_SLOTS   = DEF_TASK_SLOTS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int SLOT_W = $clog2(THREAD_SLOTS);
  localparam int CNT_W  = $clog2(THREAD_SLOTS + 1);
  localparam int OWN_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int TGT_X  = (SLOT_W > SLOT_FW) ? SLOT_W : SLOT_FW;
  localparam int OWN_X  = (OWN_W > OWNER_FW) ? OWN_W : OWNER_FW;
  localparam int CNT_X  = (CNT_W > COUNT_FW) ? CNT_W : COUNT_FW;
  localparam int ENT_W  = TID_W + OWN_W + STATE_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_e;

  fsm_e                state_q, state_d;
  req_e                op_q, op_d;
  req_t                in_q, in_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [SLOT_W-1:0]   head_q, head_d;
  logic [SLOT_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]    qlen_q, qlen_d;
  logic [CNT_W-1:0]    alloc_q, alloc_d;
  logic [SLOT_W-1:0]   cur_q, cur_d;
  logic                idle_q, idle_d;
  logic [TID_W-1:0]    tid_q, tid_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_q, out_d;

  logic                accept;
  logic                exec_go;
  req_e                in_op;
  logic [TGT_X-1:0]    in_tgt_x;
  logic [TGT_X-1:0]    q_tgt_x;
  logic [OWN_X-1:0]    own_x;
  logic                tgt_ok;
  logic                own_ok;
  logic [SLOT_W-1:0]   rd_addr;

  logic                slot_we;
  logic [SLOT_W-1:0]   slot_waddr;
  logic [ENT_W-1:0]    slot_wdata;
  logic [ENT_W-1:0]    slot_rdata;
  logic                link_we;
  logic [SLOT_W-1:0]   link_rdata;

  logic [TID_W-1:0]    ent_tid;
  logic [OWN_W-1:0]    ent_own;
  thr_state_e          rd_state;
  thr_state_e          new_state;
  logic                do_push;
  logic [SLOT_W-1:0]   push_slot;
  stat_e               r_status;
  logic [SLOT_W-1:0]   r_slot;
  logic [TID_W-1:0]    r_tid;
  thr_state_e          r_state;
  logic [TGT_X-1:0]    r_slot_x;
  logic [TGT_X-1:0]    cur_x;
  logic [CNT_X-1:0]    cnt_x;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);

  assign in_tgt_x = TGT_X'(in_data_i.target_slot);
  assign q_tgt_x  = TGT_X'(in_q.target_slot);
  assign own_x    = OWN_X'(in_q.owner_task);
  assign tgt_ok   = {1'b0, q_tgt_x} < (TGT_X + 1)'(THREAD_SLOTS);
  assign own_ok   = {1'b0, own_x} < (OWN_X + 1)'(TASK_SLOTS);

  // yield with the scheduler current behaves as dispatch
  always_comb begin
    in_op = req_e'(in_data_i.req_type);
    if (in_op == REQ_YIELD && idle_q) begin
      in_op = REQ_DISPATCH;
    end
    case (in_op) inside
      REQ_DISPATCH:                  rd_addr = head_q;
      REQ_YIELD, REQ_BLOCK, REQ_EXIT: rd_addr = cur_q;
      default:                       rd_addr = in_tgt_x[SLOT_W-1:0];
    endcase
  end

  assign ent_tid  = slot_rdata[ENT_W-1 -: TID_W];
  assign ent_own  = slot_rdata[STATE_W +: OWN_W];
  assign rd_state = (CNT_W'(slot_q) < alloc_q) ? thr_state_e'(slot_rdata[STATE_W-1:0])
                                               : ST_EMPTY;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    in_d        = in_q;
    slot_d      = slot_q;
    head_d      = head_q;
    tail_d      = tail_q;
    qlen_d      = qlen_q;
    alloc_d     = alloc_q;
    cur_d       = cur_q;
    idle_d      = idle_q;
    tid_d       = tid_q;
    slot_we     = 1'b0;
    slot_waddr  = slot_q;
    new_state   = rd_state;
    slot_wdata  = {ent_tid, ent_own, new_state};
    link_we     = 1'b0;
    do_push     = 1'b0;
    push_slot   = slot_q;
    r_status    = STAT_IGNORED;
    r_slot      = '0;
    r_tid       = '0;
    r_state     = ST_EMPTY;

    if (accept) begin
      state_d = S_EXEC;
      op_d    = in_op;
      in_d    = in_data_i;
      slot_d  = rd_addr;
    end

    if (exec_go) begin
      state_d = S_IDLE;
      case (op_q)
        REQ_CREATE: begin
          if (!in_q.args_valid || !own_ok) begin
            r_status = STAT_BADARG;
          end else if (alloc_q == CNT_W'(THREAD_SLOTS)) begin
            r_status = STAT_FULL;
          end else begin
            push_slot  = alloc_q[SLOT_W-1:0];
            slot_we    = 1'b1;
            slot_waddr = push_slot;
            slot_wdata = {tid_q, own_x[OWN_W-1:0], ST_READY};
            do_push    = 1'b1;
            tid_d      = tid_q + TID_W'(1);
            alloc_d    = alloc_q + CNT_W'(1);
            r_status   = STAT_OK;
            r_slot     = push_slot;
            r_tid      = tid_q;
            r_state    = ST_READY;
          end
        end
        REQ_DISPATCH: begin
          if (!idle_q) begin
            r_status = STAT_IGNORED;
          end else if (qlen_q == '0) begin
            r_status = STAT_EMPTYQ;
          end else begin
            new_state  = ST_RUNNING;
            slot_we    = 1'b1;
            slot_wdata = {ent_tid, ent_own, new_state};
            qlen_d     = qlen_q - CNT_W'(1);
            if (qlen_q == CNT_W'(1)) begin
              head_d = '0;
              tail_d = '0;
            end else begin
              head_d = link_rdata;
            end
            cur_d    = slot_q;
            idle_d   = 1'b0;
            r_status = STAT_OK;
            r_slot   = slot_q;
            r_tid    = ent_tid;
            r_state  = ST_RUNNING;
          end
        end
        REQ_YIELD, REQ_BLOCK, REQ_EXIT: begin
          if (idle_q) begin
            r_status = STAT_IGNORED;
          end else begin
            if (op_q == REQ_YIELD) begin
              new_state = ST_READY;
              do_push   = 1'b1;
            end else if (op_q == REQ_BLOCK) begin
              new_state = ST_BLOCKED;
            end else begin
              new_state = ST_DEAD;
            end
            slot_we    = 1'b1;
            slot_wdata = {ent_tid, ent_own, new_state};
            idle_d     = 1'b1;
            cur_d      = '0;
            r_status   = STAT_OK;
            r_slot     = slot_q;
            r_tid      = ent_tid;
            r_state    = new_state;
          end
        end
        REQ_UNBLOCK: begin
          if (!tgt_ok) begin
            r_status = STAT_BADARG;
          end else if (rd_state != ST_BLOCKED) begin
            r_status = STAT_IGNORED;
          end else begin
            new_state  = ST_READY;
            slot_we    = 1'b1;
            slot_wdata = {ent_tid, ent_own, new_state};
            do_push    = 1'b1;
            r_status   = STAT_OK;
            r_slot     = slot_q;
            r_tid      = ent_tid;
            r_state    = ST_READY;
          end
        end
        REQ_QUERY: begin
          if (!tgt_ok) begin
            r_status = STAT_BADARG;
          end else begin
            r_status = STAT_OK;
            r_slot   = slot_q;
            r_tid    = ent_tid;
            r_state  = rd_state;
          end
        end
        default: begin
          r_status = STAT_IGNORED;
        end
      endcase

      // append to the run queue tail
      if (do_push) begin
        if (qlen_q != '0) begin
          link_we = 1'b1;
        end else begin
          head_d = push_slot;
        end
        tail_d = push_slot;
        qlen_d = qlen_q + CNT_W'(1);
      end
    end
  end

  assign r_slot_x = TGT_X'(r_slot);
  assign cur_x    = TGT_X'(cur_d);
  assign cnt_x    = CNT_X'(qlen_d);

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (exec_go) begin
      out_valid_d        = 1'b1;
      out_d.status       = r_status;
      out_d.result_slot  = r_slot_x[SLOT_FW-1:0];
      out_d.result_tid   = r_tid;
      out_d.result_state = r_state;
      out_d.running_slot = cur_x[SLOT_FW-1:0];
      out_d.running_idle = idle_d;
      out_d.ready_count  = cnt_x[COUNT_FW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= REQ_CREATE;
      in_q        <= '0;
      slot_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      qlen_q      <= '0;
      alloc_q     <= '0;
      cur_q       <= '0;
      idle_q      <= 1'b1;
      tid_q       <= TID_W'(1);
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      in_q        <= in_d;
      slot_q      <= slot_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      qlen_q      <= qlen_d;
      alloc_q     <= alloc_d;
      cur_q       <= cur_d;
      idle_q      <= idle_d;
      tid_q       <= tid_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // slot table: id, owner and state of each thread
  rrts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (THREAD_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (slot_rdata)
  );

  // run queue links: next slot after each queued slot
  rrts_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (THREAD_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (tail_q),
    .wdata_i (push_slot),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (link_rdata)
  );

`ifndef SYNTHESIS
  a_qlen_le_alloc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qlen_q <= alloc_q)
    else $error("run queue longer than allocated slots");

  a_cur_allocated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle_q |-> (CNT_W'(cur_q) < alloc_q))
    else $error("running slot not allocated");

  a_idle_cur_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q |-> (cur_q == '0))
    else $error("current slot nonzero while idle");

  a_empty_queue_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qlen_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("queue pointers not cleared on empty queue");

  a_exec_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> out_valid_q)
    else $error("response not loaded after execution");
`endif

endmodule

// File: design/rrts_ram.sv
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
